// File: sv/acpe_pkg.sv
// ----------------------------------------------------------------------------
// acpe_pkg
// Shared widths, action codes and the result record of the associative
// store with parity-driven eviction.
// ----------------------------------------------------------------------------
package acpe_pkg;

    localparam int ADDR_W        = 32;
    localparam int WDATA_W       = 32;
    localparam int ACTION_W      = 2;
    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_DATA_BITS = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_READ  = 2'd0,
        ACT_PUT   = 2'd1,
        ACT_WRITE = 2'd2
    } t_action;

    typedef struct packed {
        logic                     hit;
        logic [WDATA_W-1:0]       read_data;
        logic                     evicted;
        logic signed [ADDR_W-1:0] evicted_addr;
        logic [WDATA_W-1:0]       evicted_data;
        logic                     evicted_sync;
    } t_result;

endpackage

// File: sv/acpe_in_if.sv
// ----------------------------------------------------------------------------
// acpe_in_if
// Request channel: action, address key and write data with valid/ready.
// ----------------------------------------------------------------------------
interface acpe_in_if;
    logic                             valid;
    logic                             ready;
    logic [acpe_pkg::ACTION_W-1:0]    action;
    logic signed [acpe_pkg::ADDR_W-1:0] addr;
    logic [acpe_pkg::WDATA_W-1:0]     write_data;

    modport source (output valid, output action, output addr, output write_data,
                    input ready);
    modport sink   (input valid, input action, input addr, input write_data,
                    output ready);
endinterface

// File: sv/acpe_out_if.sv
// ----------------------------------------------------------------------------
// acpe_out_if
// Response channel: hit, read data and eviction report with valid/ready.
// ----------------------------------------------------------------------------
interface acpe_out_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [acpe_pkg::WDATA_W-1:0]       read_data;
    logic                               evicted;
    logic signed [acpe_pkg::ADDR_W-1:0] evicted_addr;
    logic [acpe_pkg::WDATA_W-1:0]       evicted_data;
    logic                               evicted_sync;

    modport source (output valid, output hit, output read_data, output evicted,
                    output evicted_addr, output evicted_data, output evicted_sync,
                    input ready);
    modport sink   (input valid, input hit, input read_data, input evicted,
                    input evicted_addr, input evicted_data, input evicted_sync,
                    output ready);
endinterface

// File: sv/assoc_cache_parity_evict.sv
// Read and write scan the stored entries oldest first, one memory read per
// cycle; a hit stops the scan and its result goes to the result register.
// A write miss then inserts; an insert into a full store reads the victim
// first; put inserts directly. The memory read port sets the pace.
// One request is in flight at a time; the result register frees the request side.
// Reset clears entry count and oldest pointer; entry memory is not cleared.
// ----------------------------------------------------------------------------
// assoc_cache_parity_evict
// Fully associative address/data store in insertion order with sync marks;
// inserts into a full store evict the oldest (even key) or newest (odd key).
// ----------------------------------------------------------------------------
module assoc_cache_parity_evict #(
    parameter int ENTRIES   = acpe_pkg::DEF_ENTRIES,
    parameter int DATA_BITS = acpe_pkg::DEF_DATA_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acpe_in_if.sink    i_in,
    acpe_out_if.source o_out
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int A_W     = acpe_pkg::ADDR_W;
    localparam int WORD_W  = A_W + DATA_BITS + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_INS  = 5'b00100,
        S_EVWR = 5'b01000,
        S_NOP  = 5'b10000
    } t_state;

    t_state                r_state,     n_state;
    acpe_pkg::t_action     r_action,    n_action;
    logic [A_W-1:0]        r_addr,      n_addr;
    logic [DATA_BITS-1:0]  r_data,      n_data;
    logic [IDX_W-1:0]      r_oldest,    n_oldest;
    logic [CNT_W-1:0]      r_count,     n_count;
    logic [CNT_W-1:0]      r_issue,     n_issue;
    logic                  r_pend,      n_pend;
    logic [IDX_W-1:0]      r_pend_slot, n_pend_slot;
    logic [IDX_W-1:0]      r_victim,    n_victim;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_slot;
    logic [WORD_W-1:0]     rd_word;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_slot;
    logic [WORD_W-1:0]     wr_word;
    logic                  load;
    acpe_pkg::t_result     res;
    logic                  out_busy;
    logic                  can_finish;
    logic                  accept;
    logic                  match;
    logic [A_W-1:0]        rd_addr;
    logic [DATA_BITS-1:0]  rd_data;
    logic                  rd_sync;
    logic                  new_sync;

    function automatic logic [IDX_W-1:0] f_slot(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(ENTRIES)) begin
            sum = sum - (CNT_W+1)'(ENTRIES);
        end
        return sum[IDX_W-1:0];
    endfunction

    acpe_store #(
        .ENTRIES (ENTRIES),
        .WORD_W  (WORD_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_slot (rd_slot),
        .o_rd_word (rd_word),
        .i_wr_en   (wr_en),
        .i_wr_slot (wr_slot),
        .i_wr_word (wr_word)
    );

    acpe_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .o_busy  (out_busy),
        .o_out   (o_out)
    );

    // word layout: {sync, data, addr}
    assign rd_addr    = rd_word[A_W-1:0];
    assign rd_data    = rd_word[A_W +: DATA_BITS];
    assign rd_sync    = rd_word[WORD_W-1];
    assign new_sync   = (r_action == acpe_pkg::ACT_PUT);
    assign can_finish = !out_busy;
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign match      = r_pend && (rd_addr == r_addr);

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_addr      = r_addr;
        n_data      = r_data;
        n_oldest    = r_oldest;
        n_count     = r_count;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_victim    = r_victim;
        rd_en       = 1'b0;
        rd_slot     = '0;
        wr_en       = 1'b0;
        wr_slot     = '0;
        wr_word     = '0;
        load        = 1'b0;
        res         = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_action = acpe_pkg::t_action'(i_in.action);
                    n_addr   = $unsigned(i_in.addr);
                    n_data   = DATA_BITS'(i_in.write_data);
                    n_issue  = '0;
                    n_pend   = 1'b0;
                    if (i_in.action inside {acpe_pkg::ACT_READ, acpe_pkg::ACT_WRITE}) begin
                        n_state = S_SCAN;
                    end else if (i_in.action == acpe_pkg::ACT_PUT) begin
                        n_state = S_INS;
                    end else begin
                        n_state = S_NOP;
                    end
                end
            end
            S_NOP: begin
                if (can_finish) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (match) begin
                    // oldest match wins since the scan runs oldest first
                    if (can_finish) begin
                        load    = 1'b1;
                        res.hit = 1'b1;
                        if (r_action == acpe_pkg::ACT_WRITE) begin
                            wr_en   = 1'b1;
                            wr_slot = r_pend_slot;
                            wr_word = {1'b0, r_data, r_addr};
                        end else begin
                            res.read_data = acpe_pkg::WDATA_W'(rd_data);
                        end
                        n_state = S_IDLE;
                    end
                end else if (r_issue < r_count) begin
                    rd_en       = 1'b1;
                    rd_slot     = f_slot(r_oldest, r_issue);
                    n_issue     = r_issue + CNT_W'(1);
                    n_pend      = 1'b1;
                    n_pend_slot = rd_slot;
                end else if (r_action == acpe_pkg::ACT_WRITE) begin
                    n_pend  = 1'b0;
                    n_state = S_INS;
                end else if (can_finish) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_INS: begin
                if (r_count < CNT_W'(ENTRIES)) begin
                    if (can_finish) begin
                        wr_en   = 1'b1;
                        wr_slot = f_slot(r_oldest, r_count);
                        wr_word = {new_sync, r_data, r_addr};
                        n_count = r_count + CNT_W'(1);
                        load    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    rd_en    = 1'b1;
                    rd_slot  = r_addr[0] ? f_slot(r_oldest, CNT_W'(ENTRIES - 1)) : r_oldest;
                    n_victim = rd_slot;
                    n_state  = S_EVWR;
                end
            end
            S_EVWR: begin
                // the new entry always lands in the victim's slot
                if (can_finish) begin
                    wr_en            = 1'b1;
                    wr_slot          = r_victim;
                    wr_word          = {new_sync, r_data, r_addr};
                    load             = 1'b1;
                    res.evicted      = 1'b1;
                    res.evicted_addr = $signed(rd_addr);
                    res.evicted_data = acpe_pkg::WDATA_W'(rd_data);
                    res.evicted_sync = rd_sync;
                    if (!r_addr[0]) begin
                        n_oldest = f_slot(r_oldest, CNT_W'(1));
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_issue  <= '0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_issue  <= n_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_addr      <= n_addr;
        r_data      <= n_data;
        r_pend_slot <= n_pend_slot;
        r_victim    <= n_victim;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count above capacity");

    a_oldest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oldest < IDX_W'(ENTRIES - 1) || r_oldest == IDX_W'(ENTRIES - 1))
        else $error("oldest pointer out of range");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && res.evicted |-> r_count == CNT_W'(ENTRIES))
        else $error("eviction from a store that is not full");

    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("memory read and write in the same cycle");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_out.valid)
        else $error("finished result not presented");
`endif

endmodule

// File: sv/acpe_store.sv
// ----------------------------------------------------------------------------
// acpe_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module acpe_store #(
    parameter int ENTRIES = acpe_pkg::DEF_ENTRIES,
    parameter int WORD_W  = acpe_pkg::ADDR_W + acpe_pkg::DEF_DATA_BITS + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_slot,
    output logic [WORD_W-1:0]          o_rd_word,
    input  logic                       i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_slot,
    input  logic [WORD_W-1:0]          i_wr_word
);

    logic [WORD_W-1:0] r_mem [ENTRIES];
    logic [WORD_W-1:0] r_rd_word;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_slot] <= i_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_slot];
        end
    end

    assign o_rd_word = r_rd_word;

endmodule

// File: sv/acpe_outreg.sv
// ----------------------------------------------------------------------------
// acpe_outreg
// Result register: holds one finished result beat until the sink takes it.
// ----------------------------------------------------------------------------
module acpe_outreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  acpe_pkg::t_result i_res,
    output logic              o_busy,
    acpe_out_if.source        o_out
);

    logic              r_valid;
    logic              n_valid;
    acpe_pkg::t_result r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    // a new result may land in the same cycle the old one leaves
    assign o_busy             = r_valid && !o_out.ready;
    assign o_out.valid        = r_valid;
    assign o_out.hit          = r_res.hit;
    assign o_out.read_data    = r_res.read_data;
    assign o_out.evicted      = r_res.evicted;
    assign o_out.evicted_addr = r_res.evicted_addr;
    assign o_out.evicted_data = r_res.evicted_data;
    assign o_out.evicted_sync = r_res.evicted_sync;

endmodule

// File: tb/acpe_lookup_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// acpe_lookup_checker
// Watches the request and response channels of the associative store, keeps
// its own copy of the entry queue, predicts every response and compares each
// field of the responses, in order, with the predicted ones.
// ----------------------------------------------------------------------------
module acpe_lookup_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    acpe_in_if   i_req,
    acpe_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int ADDR_W    = acpe_pkg::ADDR_W;
    localparam int WDATA_W   = acpe_pkg::WDATA_W;
    localparam int ACTION_W  = acpe_pkg::ACTION_W;
    localparam int SLOTS     = acpe_pkg::DEF_ENTRIES;
    localparam int KEEP_BITS = (acpe_pkg::DEF_DATA_BITS < WDATA_W) ?
                               acpe_pkg::DEF_DATA_BITS : WDATA_W;
    localparam logic [WDATA_W-1:0] DATA_MASK = {WDATA_W{1'b1}} >> (WDATA_W - KEEP_BITS);

    logic signed [ADDR_W-1:0] slot_key  [SLOTS];
    logic [WDATA_W-1:0]       slot_word [SLOTS];
    logic                     slot_clean[SLOTS];
    int                       head_slot;
    int                       fill_count;

    acpe_pkg::t_result expected_responses[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        head_slot    = 0;
        fill_count   = 0;
    end

    // oldest matching slot, -1 on a miss
    function automatic int oldest_match(logic signed [ADDR_W-1:0] key);
        int slot;
        for (int age = 0; age < fill_count; age++) begin
            slot = (head_slot + age) % SLOTS;
            if (slot_key[slot] == key)
                return slot;
        end
        return -1;
    endfunction

    function automatic void append_entry(logic signed [ADDR_W-1:0] key,
                                         logic [WDATA_W-1:0] word, logic clean,
                                         inout acpe_pkg::t_result res);
        int victim;
        int slot;
        if (fill_count >= SLOTS) begin
            // even key drops the oldest entry, odd key the newest
            if (key[0] == 1'b0) begin
                victim    = head_slot;
                head_slot = (head_slot + 1) % SLOTS;
            end else begin
                victim = (head_slot + fill_count - 1) % SLOTS;
            end
            fill_count--;
            res.evicted      = 1'b1;
            res.evicted_addr = slot_key[victim];
            res.evicted_data = slot_word[victim];
            res.evicted_sync = slot_clean[victim];
        end
        slot             = (head_slot + fill_count) % SLOTS;
        slot_key[slot]   = key;
        slot_word[slot]  = word;
        slot_clean[slot] = clean;
        fill_count++;
    endfunction

    function automatic acpe_pkg::t_result cache_access(logic [ACTION_W-1:0] act,
                                                       logic signed [ADDR_W-1:0] key,
                                                       logic [WDATA_W-1:0] word);
        acpe_pkg::t_result res;
        int                slot;
        res  = '0;
        word = word & DATA_MASK;
        case (act)
            acpe_pkg::ACT_READ: begin
                slot = oldest_match(key);
                if (slot >= 0) begin
                    res.hit       = 1'b1;
                    res.read_data = slot_word[slot];
                end
            end
            acpe_pkg::ACT_PUT: begin
                append_entry(key, word, 1'b1, res);
            end
            acpe_pkg::ACT_WRITE: begin
                slot = oldest_match(key);
                if (slot >= 0) begin
                    res.hit          = 1'b1;
                    slot_word[slot]  = word;
                    slot_clean[slot] = 1'b0;
                end else begin
                    append_entry(key, word, 1'b0, res);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic bit field_matches(string name, logic [WDATA_W-1:0] want,
                                         logic [WDATA_W-1:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, seen);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor
        acpe_pkg::t_result want;
        bit                ok;
        if (!i_rst_n) begin
            head_slot  = 0;
            fill_count = 0;
            expected_responses.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                expected_responses.push_back(cache_access(i_req.action, i_req.addr,
                                                          i_req.write_data));
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_responses.size() == 0) begin
                    $display("%0t: response beat with nothing expected", $time);
                    o_fail_count++;
                end else begin
                    want = expected_responses.pop_front();
                    ok = field_matches("hit", want.hit, i_rsp.hit)
                       & field_matches("read_data", want.read_data, i_rsp.read_data)
                       & field_matches("evicted", want.evicted, i_rsp.evicted)
                       & field_matches("evicted_addr", want.evicted_addr, i_rsp.evicted_addr)
                       & field_matches("evicted_data", want.evicted_data, i_rsp.evicted_data)
                       & field_matches("evicted_sync", want.evicted_sync, i_rsp.evicted_sync);
                    if (!ok)
                        o_fail_count++;
                end
            end
        end
        o_pending = expected_responses.size();
    end

endmodule

// File: tb/tb_assoc_cache_parity_evict.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_assoc_cache_parity_evict
// Drives reads, puts and writes into the associative store: a directed run
// through empty, duplicate and full-store eviction cases, then random traffic
// over a small hot key set under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_assoc_cache_parity_evict;

    localparam int ACTION_W = acpe_pkg::ACTION_W;
    localparam int ADDR_W   = acpe_pkg::ADDR_W;
    localparam int WDATA_W  = acpe_pkg::WDATA_W;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic signed [ADDR_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ADDR_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam int HOT_KEYS       = 20;
    localparam int ITEMS_PER_MIX  = 331;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    acpe_in_if  req_if();
    acpe_out_if rsp_if();

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int quiet_cycles   = 0;

    logic signed [ADDR_W-1:0] hot_keys[HOT_KEYS];

    always #5 i_clk = ~i_clk;

    assoc_cache_parity_evict dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_if),
        .o_out  (rsp_if)
    );

    acpe_lookup_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    task automatic send_item(input logic [ACTION_W-1:0] act,
                             input logic signed [ADDR_W-1:0] key,
                             input logic [WDATA_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.addr       <= key;
        req_if.write_data <= word;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
    endtask

    // response side: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left    = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_assoc_cache_parity_evict failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int                       roll;
        logic [ACTION_W-1:0]      act;
        logic signed [ADDR_W-1:0] key;

        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.action     = acpe_pkg::ACT_READ;
        req_if.addr       = '0;
        req_if.write_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty miss, extremes, update, duplicate, unused code
        send_item(acpe_pkg::ACT_READ, 32'sd0, 32'hFFFF_FFFF);
        send_item(acpe_pkg::ACT_PUT, KEY_MAX, 32'hFFFF_FFFF);
        send_item(acpe_pkg::ACT_PUT, KEY_MIN, 32'h0000_0000);
        send_item(acpe_pkg::ACT_READ, KEY_MAX, 32'h0);
        send_item(acpe_pkg::ACT_READ, KEY_MIN, 32'hFFFF_FFFF);
        send_item(acpe_pkg::ACT_WRITE, KEY_MAX, 32'h1234_5678);
        send_item(acpe_pkg::ACT_WRITE, -32'sd1, 32'hA5A5_A5A5);
        send_item(acpe_pkg::ACT_PUT, KEY_MAX, 32'h0000_DEAD);
        send_item(acpe_pkg::ACT_READ, KEY_MAX, 32'h0);
        send_item(ACT_UNUSED, KEY_MAX, 32'h5A5A_5A5A);
        send_item(acpe_pkg::ACT_READ, -32'sd1, 32'h0);
        // fill up to a full store
        for (int k = 0; k < 12; k++)
            send_item(acpe_pkg::ACT_PUT, 32'sd100 + k, $urandom);
        // full: even key drops oldest (dirty), odd write miss drops newest (clean)
        send_item(acpe_pkg::ACT_PUT, -32'sd2, 32'h0F0F_0F0F);
        send_item(acpe_pkg::ACT_WRITE, 32'sd77, 32'hF0F0_F0F0);

        hot_keys[0] = 32'sd0;
        hot_keys[1] = 32'sd1;
        hot_keys[2] = -32'sd1;
        hot_keys[3] = -32'sd2;
        hot_keys[4] = KEY_MAX;
        hot_keys[5] = KEY_MIN;

        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int k = 6; k < HOT_KEYS; k++)
                hot_keys[k] = $urandom;
            for (int n = 0; n < ITEMS_PER_MIX; n++) begin
                if (mix == 0 && n == 150)
                    hold_req = 1'b1;
                roll = $urandom_range(99);
                if (roll < 2)
                    act = ACT_UNUSED;
                else if (roll < 40)
                    act = acpe_pkg::ACT_READ;
                else if (roll < 65)
                    act = acpe_pkg::ACT_PUT;
                else
                    act = acpe_pkg::ACT_WRITE;
                key = ($urandom_range(3) != 0) ? hot_keys[$urandom_range(HOT_KEYS - 1)]
                                               : $urandom;
                send_item(act, key, $urandom);
            end
        end
        req_if.valid   <= 1'b0;
        recv_stall_pct  = 0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb_assoc_cache_parity_evict passed");
        else
            $display("tb_assoc_cache_parity_evict failed");
        $finish;
    end

endmodule
